[hw/rtl/fibonacci_mod_matrix_power_defines.svh]
// Assertion macros for the Fibonacci matrix power block.
// Used by fibonacci_mod_matrix_power.sv; needs signals clk and rst_n in scope.
`ifndef FIBONACCI_MOD_MATRIX_POWER_DEFINES_SVH
`define FIBONACCI_MOD_MATRIX_POWER_DEFINES_SVH
`ifndef SYNTHESIS
`define FMP_ASSERT(label, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("fmp assertion failed");
`define FMP_ASSERT_NEXT(label, cond, nxt) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (nxt)) \
    else $error("fmp assertion failed");
`else
`define FMP_ASSERT(label, prop)
`define FMP_ASSERT_NEXT(label, cond, nxt)
`endif
`endif

[hw/rtl/fmp_pkg.sv]
// Constants and modular arithmetic helpers for the Fibonacci matrix power block.
// No dependencies.
package fmp_pkg;

  localparam int VAL_BITS = 30;
  localparam logic [VAL_BITS-1:0] FIB_P = 30'd1000000007;
  localparam logic [VAL_BITS+1:0] FIB_P2 = 32'd2000000014;
  localparam logic [4:0] BCNT_LAST = 5'd29;

  typedef logic [VAL_BITS-1:0] val_t;

  function automatic val_t add_mod(input val_t x, input val_t y);
    logic [VAL_BITS:0] t;
    t = {1'b0, x} + {1'b0, y};
    if (t >= {1'b0, FIB_P}) begin
      t = t - {1'b0, FIB_P};
    end
    return t[VAL_BITS-1:0];
  endfunction

  // One bit of an interleaved modular multiply-accumulate: 2r + b1*x1 + b2*x2.
  function automatic val_t mac_step(input val_t r, input val_t x1, input val_t x2,
                                    input logic b1, input logic b2);
    logic [VAL_BITS+1:0] t;
    t = {1'b0, r, 1'b0} + {2'b00, (b1 ? x1 : '0)} + {2'b00, (b2 ? x2 : '0)};
    if (t >= FIB_P2) begin
      t = t - FIB_P2;
    end
    if (t >= {2'b00, FIB_P}) begin
      t = t - {2'b00, FIB_P};
    end
    return t[VAL_BITS-1:0];
  endfunction

endpackage

[hw/rtl/fibonacci_mod_matrix_power.sv]
// Top level of the Fibonacci matrix power block, modulo 1000000007.
// Depends on fmp_pkg and fibonacci_mod_matrix_power_defines.svh.
//
// A request on the input channel carries an index n; the block returns one
// result, F(n) mod 1000000007, on the output channel. Both channels use
// valid and stall; a transfer happens at a clock edge with valid high and
// stall low. The block holds one request at a time and raises in_stall
// while it works.
// Indexes zero, one and two go straight from idle to the done state. Larger
// indexes scan all INDEX_BITS bits of n-2, each bit taking a bit-serial matrix
// squaring on four modular multiply-accumulate units plus a step for the
// optional multiply by the base matrix. The squaring loop sets the latency.
// The result waits in an output register while out_stall is high, and a new
// request may be taken meanwhile. Synchronous reset clears the sequencer and
// the output valid.
`include "fibonacci_mod_matrix_power_defines.svh"
module fibonacci_mod_matrix_power #(
  parameter int INDEX_BITS = 63
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [INDEX_BITS-1:0] in_index,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [29:0]           out_fib_value
);
  import fmp_pkg::*;

  localparam int EW = $clog2(INDEX_BITS);

  typedef enum logic [2:0] {S_IDLE, S_SQR, S_MULB, S_FIN, S_DONE} state_t;

  state_t                state_r;
  val_t                  a_r, b_r, c_r, d_r;
  val_t                  sa_r, sb_r, sc_r, sd_r;
  val_t                  ra_r, rb_r, rc_r, rd_r;
  val_t                  res_r;
  logic [INDEX_BITS-1:0] e_r;
  logic [EW-1:0]         ecnt_r;
  logic [4:0]            bcnt_r;
  logic                  out_valid_r;
  val_t                  out_fib_value_r;

  val_t ra_nxt, rb_nxt, rc_nxt, rd_nxt;
  val_t na_nxt, nb_nxt, nc_nxt, nd_nxt;
  logic ebit;

  assign ebit = e_r[INDEX_BITS-1];
  assign ra_nxt = mac_step(ra_r, a_r, b_r, sa_r[VAL_BITS-1], sc_r[VAL_BITS-1]);
  assign rb_nxt = mac_step(rb_r, a_r, b_r, sb_r[VAL_BITS-1], sd_r[VAL_BITS-1]);
  assign rc_nxt = mac_step(rc_r, c_r, d_r, sa_r[VAL_BITS-1], sc_r[VAL_BITS-1]);
  assign rd_nxt = mac_step(rd_r, c_r, d_r, sb_r[VAL_BITS-1], sd_r[VAL_BITS-1]);

  always_comb begin
    na_nxt = a_r;
    nb_nxt = b_r;
    nc_nxt = c_r;
    nd_nxt = d_r;
    if (ebit) begin
      na_nxt = add_mod(a_r, b_r);
      nb_nxt = a_r;
      nc_nxt = add_mod(c_r, d_r);
      nd_nxt = c_r;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_fib_value = out_fib_value_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (state_r == S_DONE && (!out_valid_r || !out_stall)) begin
        out_valid_r     <= 1'b1;
        out_fib_value_r <= res_r;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            if (in_index == '0) begin
              res_r   <= '0;
              state_r <= S_DONE;
            end else if (in_index == INDEX_BITS'(1) || in_index == INDEX_BITS'(2)) begin
              res_r   <= val_t'(1);
              state_r <= S_DONE;
            end else begin
              e_r     <= in_index - INDEX_BITS'(2);
              ecnt_r  <= EW'(INDEX_BITS - 1);
              a_r     <= val_t'(1);
              b_r     <= '0;
              c_r     <= '0;
              d_r     <= val_t'(1);
              sa_r    <= val_t'(1);
              sb_r    <= '0;
              sc_r    <= '0;
              sd_r    <= val_t'(1);
              ra_r    <= '0;
              rb_r    <= '0;
              rc_r    <= '0;
              rd_r    <= '0;
              bcnt_r  <= '0;
              state_r <= S_SQR;
            end
          end
        end
        S_SQR: begin
          ra_r   <= ra_nxt;
          rb_r   <= rb_nxt;
          rc_r   <= rc_nxt;
          rd_r   <= rd_nxt;
          sa_r   <= {sa_r[VAL_BITS-2:0], 1'b0};
          sb_r   <= {sb_r[VAL_BITS-2:0], 1'b0};
          sc_r   <= {sc_r[VAL_BITS-2:0], 1'b0};
          sd_r   <= {sd_r[VAL_BITS-2:0], 1'b0};
          bcnt_r <= bcnt_r + 5'd1;
          if (bcnt_r == BCNT_LAST) begin
            a_r     <= ra_nxt;
            b_r     <= rb_nxt;
            c_r     <= rc_nxt;
            d_r     <= rd_nxt;
            state_r <= S_MULB;
          end
        end
        S_MULB: begin
          a_r <= na_nxt;
          b_r <= nb_nxt;
          c_r <= nc_nxt;
          d_r <= nd_nxt;
          e_r <= {e_r[INDEX_BITS-2:0], 1'b0};
          if (ecnt_r == '0) begin
            state_r <= S_FIN;
          end else begin
            ecnt_r  <= ecnt_r - EW'(1);
            sa_r    <= na_nxt;
            sb_r    <= nb_nxt;
            sc_r    <= nc_nxt;
            sd_r    <= nd_nxt;
            ra_r    <= '0;
            rb_r    <= '0;
            rc_r    <= '0;
            rd_r    <= '0;
            bcnt_r  <= '0;
            state_r <= S_SQR;
          end
        end
        S_FIN: begin
          res_r   <= add_mod(a_r, b_r);
          state_r <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_r || !out_stall) begin
            state_r <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  `FMP_ASSERT(a_out_reduced, out_valid_r |-> (out_fib_value_r < FIB_P))
  `FMP_ASSERT(a_bcnt_range, (state_r == S_SQR) |-> (bcnt_r <= BCNT_LAST))
  `FMP_ASSERT(a_acc_reduced, (state_r == S_MULB) |-> (a_r < FIB_P && b_r < FIB_P))
  `FMP_ASSERT_NEXT(a_done_issues, state_r == S_DONE && !out_stall, out_valid_r)

endmodule

[tb/fibonacci_mod_matrix_power_test.sv]
// Testbench for fibonacci_mod_matrix_power: checks F(n) mod 1000000007 per request.
// Depends on the RTL top level only; predicts results with its own matrix powering.
`timescale 1ns / 100ps
module fibonacci_mod_matrix_power_test;

  localparam int INDEX_W = 63;
  localparam longint unsigned PRIME = 64'd1000000007;

  class fib_scoreboard;
    bit [29:0] pending[$];
    int errors;

    function bit [29:0] fib_of(bit [INDEX_W-1:0] n);
      longint unsigned acc[4];
      longint unsigned t[4];
      bit [63:0] e;
      if (n == 0) return 30'd0;
      if (n <= 2) return 30'd1;
      e = {1'b0, n} - 64'd2;
      acc = '{1, 0, 0, 1};
      for (int i = 63; i >= 0; i--) begin
        t[0] = (acc[0] * acc[0] % PRIME + acc[1] * acc[2] % PRIME) % PRIME;
        t[1] = (acc[0] * acc[1] % PRIME + acc[1] * acc[3] % PRIME) % PRIME;
        t[2] = (acc[2] * acc[0] % PRIME + acc[3] * acc[2] % PRIME) % PRIME;
        t[3] = (acc[2] * acc[1] % PRIME + acc[3] * acc[3] % PRIME) % PRIME;
        acc = t;
        if (e[i]) begin
          t[0] = (acc[0] + acc[1]) % PRIME;
          t[1] = acc[0];
          t[2] = (acc[2] + acc[3]) % PRIME;
          t[3] = acc[2];
          acc = t;
        end
      end
      return 30'((acc[0] + acc[1]) % PRIME);
    endfunction

    function void note_request(bit [INDEX_W-1:0] n);
      pending = {pending, fib_of(n)};
    endfunction

    task report(string msg);
      $display("ERROR: %s", msg);
      errors++;
    endtask

    task check_result(bit [29:0] got);
      bit [29:0] want;
      if (pending.size() == 0) begin
        report($sformatf("unexpected result %0d", got));
        return;
      end
      want = pending.pop_front();
      if (got !== want) begin
        report($sformatf("fib_value %0d, expected %0d", got, want));
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [INDEX_W-1:0] in_index = '0;
  logic out_valid;
  logic out_stall = 1'b1;
  logic [29:0] out_fib_value;

  fib_scoreboard fib_sb = new();
  bit calm = 1'b0;
  bit stim_done = 1'b0;

  fibonacci_mod_matrix_power #(.INDEX_BITS(INDEX_W)) u_top (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_index(in_index),
    .out_valid(out_valid), .out_stall(out_stall), .out_fib_value(out_fib_value)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task automatic send_index(input bit [INDEX_W-1:0] n);
    int gap;
    if (!calm && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 12);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_index <= n;
    do @(posedge clk); while (in_stall);
    fib_sb.note_request(n);
    @(negedge clk);
  endtask

  function automatic bit [INDEX_W-1:0] rand_index();
    bit [INDEX_W-1:0] v;
    v = INDEX_W'({$urandom(), $urandom()});
    case ($urandom_range(0, 5))
      0: v = INDEX_W'($urandom_range(0, 40));
      1: v = v >> $urandom_range(0, 62);
      2: v = ~(v >> $urandom_range(0, 62));
      default: ;
    endcase
    return v;
  endfunction

  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b1;
    end else if (calm) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 7) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 12) - 1) @(negedge clk);
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) fib_sb.check_result(out_fib_value);
  end

  initial begin
    bit [INDEX_W-1:0] directed[$];
    directed = '{0, 1, 2, 3, 4, 5, 10, 45, 46, 100, 1000000007, 2000000016,
                 {INDEX_W{1'b1}}, {INDEX_W{1'b1}} - 1, {1'b1, {(INDEX_W-1){1'b0}}},
                 INDEX_W'(64'h2AAA_AAAA_AAAA_AAAA), INDEX_W'(64'h5555_5555_5555_5555)};
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    foreach (directed[i]) send_index(directed[i]);
    for (int k = 0; k < 530; k++) begin
      if (k == 200) begin
        in_valid <= 1'b0;
        while (fib_sb.pending.size() != 0) @(negedge clk);
      end
      if (k == 450) calm = 1'b1;
      send_index(rand_index());
    end
    in_valid <= 1'b0;
    while (fib_sb.pending.size() != 0) @(negedge clk);
    repeat (50) @(negedge clk);
    if (fib_sb.errors == 0 && fib_sb.pending.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #20000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

[files.f]
+incdir+hw/rtl
hw/rtl/fmp_pkg.sv
hw/rtl/fibonacci_mod_matrix_power.sv
tb/fibonacci_mod_matrix_power_test.sv
